// ===== rtl/core/error_function_approx_unit_macros.svh =====
// assertion helpers for the error function unit
`ifndef ERROR_FUNCTION_APPROX_UNIT_MACROS_SVH
`define ERROR_FUNCTION_APPROX_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define EFA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/efa_pkg.sv =====
package efa_pkg;

    localparam int XW        = 16;
    localparam int MAGW      = 13;
    localparam int Q30W      = 31;
    localparam int SW        = 34;
    localparam int RESW      = 15;
    localparam int TERMS     = 13;
    localparam int SQUARES   = 4;
    localparam int HSTEPS    = 6;
    localparam int RSHIFT    = 35;

    localparam logic [Q30W-1:0] ONE_Q30  = 31'd1073741824;
    localparam logic [29:0]     HALF_Q30 = 30'd536870912;
    localparam logic [28:0]     P_Q30    = 29'd351748265;
    localparam logic signed [SW-1:0] A1_Q30 = 34'sd273621191;
    localparam logic signed [SW-1:0] A2_Q30 = -34'sd305476044;
    localparam logic signed [SW-1:0] A3_Q30 = 34'sd1526231383;
    localparam logic signed [SW-1:0] A4_Q30 = -34'sd1560310108;
    localparam logic signed [SW-1:0] A5_Q30 = 34'sd1139675401;

    localparam logic [MAGW+3:0]  SAT_LIMIT = 17'd8192;
    localparam logic [RESW-1:0]  OUT_ONE   = 15'd16384;

    localparam int LAT_RECIP = 1 + Q30W;
    localparam int LAT_EXP   = 1 + 3 * TERMS + 1 + SQUARES;
    localparam int LAT_TPAD  = LAT_EXP - LAT_RECIP;
    localparam int LAT_HORN  = 2 * HSTEPS + 1;
    localparam int LAT_TOTAL = LAT_EXP + LAT_HORN;

    // side information that rides along with each sample
    typedef struct packed {
        logic vld;
        logic neg;
        logic sat;
    } t_side;

    // ceil(2^35 / k): exact quotient by k for values below 2^31
    function automatic logic [35:0] recip_k(input int k);
        logic [35:0] m;
        case (k)
            1:       m = 36'd34359738368;
            2:       m = 36'd17179869184;
            3:       m = 36'd11453246123;
            4:       m = 36'd8589934592;
            5:       m = 36'd6871947674;
            6:       m = 36'd5726623062;
            7:       m = 36'd4908534053;
            8:       m = 36'd4294967296;
            9:       m = 36'd3817748708;
            10:      m = 36'd3435973837;
            11:      m = 36'd3123612579;
            12:      m = 36'd2863311531;
            13:      m = 36'd2643056798;
            default: m = 36'd0;
        endcase
        return m;
    endfunction

    // addend after each Horner product
    function automatic logic signed [SW-1:0] horner_add(input int j);
        logic signed [SW-1:0] a;
        case (j)
            0:       a = A4_Q30;
            1:       a = A3_Q30;
            2:       a = A2_Q30;
            3:       a = A1_Q30;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/error_function_approx_unit.sv =====
// channel   | direction | payload (lowest bit first)
// s_axis    | in        | tdata[15:0] sample_x, signed Q4.11
// m_axis    | out       | tdata[15:0] erf_value, signed Q1.14
//
// one sample per cycle while the skid slot is empty; every sample gives one result after passing
// 45 stages of exp series and squaring, then 13 of Horner steps and rounding, plus the output
// register; the 32-stage reciprocal runs beside the exp and is padded by 13 to line up
// synchronous active-low reset clears the side info pipe and the output/skid valid flags only
// a stall at the output is absorbed by a skid slot; the pipeline freezes while the skid is full
// |x| >= 4 bypasses the math and saturates to +/-1

`include "error_function_approx_unit_macros.svh"

module error_function_approx_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,    // [15:0] sample_x
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata     // [15:0] erf_value
);
    import efa_pkg::*;

    // pipeline advance: the whole pipe moves unless the skid slot is occupied
    logic w_en;

    // magnitude and sign of the incoming sample
    logic            w_neg;
    logic [XW:0]     w_mag;
    logic            w_sat;

    logic [Q30W-1:0] w_t;
    logic [Q30W-1:0] w_e;
    logic [RESW-1:0] w_res;

    // side info per stage, valid bit included
    t_side           r_side [LAT_TOTAL];
    logic [Q30W-1:0] r_tpad [LAT_TPAD];

    // result at the pipe end
    logic [RESW-1:0] w_fin;
    logic [XW-1:0]   w_out;
    t_side           w_end;

    // output register and skid slot
    logic            r_out_vld;
    logic [XW-1:0]   r_out_data;
    logic            r_skid_vld;
    logic [XW-1:0]   r_skid_data;

    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    assign w_neg = i_s_axis_tdata[XW-1];
    assign w_mag = w_neg ? (XW+1)'(-$signed({i_s_axis_tdata[XW-1], i_s_axis_tdata}))
                         : {1'b0, i_s_axis_tdata};
    assign w_sat = w_mag >= SAT_LIMIT;

    // reciprocal t = 1/(1+p|x|)
    efa_recip u_recip (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (w_mag[MAGW-1:0]),
        .o_t   (w_t)
    );

    // exp(-x*x)
    efa_exp u_exp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (w_mag[MAGW-1:0]),
        .o_e   (w_e)
    );

    // t arrives earlier than exp; delay it to line up
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tpad[0] <= w_t;
            for (int i = 1; i < LAT_TPAD; i++) begin
                r_tpad[i] <= r_tpad[i-1];
            end
        end
    end

    // polynomial, product and final rounding
    efa_horner u_horner (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (r_tpad[LAT_TPAD-1]),
        .i_e   (w_e),
        .o_res (w_res)
    );

    // sign, saturation flag and valid follow the sample through the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT_TOTAL; i++) begin
                r_side[i] <= '0;
            end
        end else if (w_en) begin
            r_side[0] <= '{vld: i_s_axis_tvalid, neg: w_neg, sat: w_sat};
            for (int i = 1; i < LAT_TOTAL; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    assign w_end = r_side[LAT_TOTAL-1];
    assign w_fin = (w_end.sat || w_res > OUT_ONE) ? OUT_ONE : w_res;
    assign w_out = w_end.neg ? XW'(-$signed({1'b0, w_fin})) : XW'(w_fin);

    // output slot with skid: a new result goes to the output if it frees up, else to the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_end.vld) begin
            if (!r_out_vld || i_m_axis_tready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_end.vld) begin
            if (!r_out_vld || i_m_axis_tready) begin
                r_out_data <= w_out;
            end else begin
                r_skid_data <= w_out;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // skid only fills behind a held output
    `EFA_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld, "skid full with empty output")
    // draining the skid refills the output and frees the pipe
    `EFA_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_vld && i_m_axis_tready, r_out_vld && !r_skid_vld, "skid drain lost a result")
    // erf stays within plus or minus one
    `EFA_ASSERT_IMPLY(a_out_range, i_clk, i_rst_n, o_m_axis_tvalid, $signed(o_m_axis_tdata) <= 16'sd16384 && $signed(o_m_axis_tdata) >= -16'sd16384, "erf out of range")

endmodule

// ===== rtl/core/efa_recip.sv =====
module efa_recip (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [efa_pkg::MAGW-1:0]    i_mag,
    output logic [efa_pkg::Q30W-1:0]    o_t
);
    import efa_pkg::*;

    logic [31:0]     r_den0;
    logic [31:0]     r_rem [Q30W];
    logic [31:0]     r_den [Q30W];
    logic [Q30W-1:0] r_q   [Q30W];

    // denominator 1 + p*a in Q30
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den0 <= 32'({2'b0, ONE_Q30}
                + ((42'(P_Q30) * 42'(i_mag) + 42'd1024) >> 11));
        end
    end

    // one quotient bit per stage; the rounding half of den is the low dividend part
    for (genvar s = 0; s < Q30W; s++) begin : g_div
        logic [31:0]     rem_in;
        logic [31:0]     den_in;
        logic [Q30W-1:0] q_in;
        logic [32:0]     trial;
        logic            take;

        if (s == 0) begin : g_first
            assign rem_in = 32'd536870912;
            assign den_in = r_den0;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign q_in   = r_q[s-1];
        end

        assign trial = {rem_in, den_in[31-s]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? 32'(trial - {1'b0, den_in}) : trial[31:0];
                r_den[s] <= den_in;
                r_q[s]   <= {q_in[Q30W-2:0], take};
            end
        end
    end

    assign o_t = r_q[Q30W-1];

endmodule

// ===== rtl/core/efa_exp.sv =====
module efa_exp (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [efa_pkg::MAGW-1:0]    i_mag,
    output logic [efa_pkg::Q30W-1:0]    o_e
);
    import efa_pkg::*;

    logic [29:0]            r_v;
    logic [60:0]            r_a_p   [TERMS];
    logic signed [32:0]     r_a_sum [TERMS];
    logic [29:0]            r_a_v   [TERMS];
    logic [Q30W-1:0]        r_b_x   [TERMS];
    logic signed [32:0]     r_b_sum [TERMS];
    logic [29:0]            r_b_v   [TERMS];
    logic [66:0]            r_c_y   [TERMS];
    logic signed [32:0]     r_c_sum [TERMS];
    logic [29:0]            r_c_v   [TERMS];
    logic [Q30W-1:0]        r_sq    [SQUARES+1];

    // a*a/16 in Q30
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= {26'(i_mag * i_mag), 4'b0};
        end
    end

    // taylor series, three stages per term: product by v, round, divide by k
    for (genvar j = 0; j < TERMS; j++) begin : g_term
        logic [Q30W-1:0]    term_in;
        logic signed [32:0] sum_in;
        logic [29:0]        v_in;

        if (j == 0) begin : g_first
            assign term_in = ONE_Q30;
            assign sum_in  = 33'(ONE_Q30);
            assign v_in    = r_v;
        end else begin : g_next
            assign term_in = r_c_y[j-1][RSHIFT+Q30W-1:RSHIFT];
            assign v_in    = r_c_v[j-1];
            if (j % 2 == 1) begin : g_sub
                assign sum_in = r_c_sum[j-1] - $signed({2'b0, term_in});
            end else begin : g_add
                assign sum_in = r_c_sum[j-1] + $signed({2'b0, term_in});
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_p[j]   <= 61'(term_in) * 61'(v_in);
                r_a_sum[j] <= sum_in;
                r_a_v[j]   <= v_in;
                r_b_x[j]   <= 31'((r_a_p[j] + 61'(HALF_Q30)) >> 30) + 31'((j + 1) / 2);
                r_b_sum[j] <= r_a_sum[j];
                r_b_v[j]   <= r_a_v[j];
                r_c_y[j]   <= 67'(r_b_x[j]) * 67'(recip_k(j + 1));
                r_c_sum[j] <= r_b_sum[j];
                r_c_v[j]   <= r_b_v[j];
            end
        end
    end

    // last term (odd, subtracted), then clamp to [0, 1]
    logic signed [32:0] w_sum_last;
    assign w_sum_last = r_c_sum[TERMS-1]
        - $signed({2'b0, r_c_y[TERMS-1][RSHIFT+Q30W-1:RSHIFT]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_sum_last < 0) begin
                r_sq[0] <= '0;
            end else if (w_sum_last > $signed({2'b0, ONE_Q30})) begin
                r_sq[0] <= ONE_Q30;
            end else begin
                r_sq[0] <= w_sum_last[Q30W-1:0];
            end
        end
    end

    // exp(-v) to the 16th power
    for (genvar i = 0; i < SQUARES; i++) begin : g_sq
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[i+1] <= 31'((62'(r_sq[i]) * 62'(r_sq[i]) + 62'(HALF_Q30)) >> 30);
            end
        end
    end

    assign o_e = r_sq[SQUARES];

endmodule

// ===== rtl/core/efa_horner.sv =====
module efa_horner (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [efa_pkg::Q30W-1:0]    i_t,
    input  logic [efa_pkg::Q30W-1:0]    i_e,
    output logic [efa_pkg::RESW-1:0]    o_res
);
    import efa_pkg::*;

    logic [62:0]            r_m_mag [HSTEPS];
    logic                   r_m_neg [HSTEPS];
    logic [Q30W-1:0]        r_m_t   [HSTEPS];
    logic [Q30W-1:0]        r_m_e   [HSTEPS];
    logic signed [SW-1:0]   r_r_s   [HSTEPS];
    logic [Q30W-1:0]        r_r_t   [HSTEPS];
    logic [Q30W-1:0]        r_r_e   [HSTEPS];
    logic [RESW-1:0]        r_res;

    // each step: sign-magnitude product, then round half away and add the next coefficient
    for (genvar j = 0; j < HSTEPS; j++) begin : g_step
        logic signed [SW-1:0] s_in;
        logic [Q30W-1:0]      t_in;
        logic [Q30W-1:0]      e_in;
        logic [Q30W-1:0]      op;
        logic [31:0]          mag;
        logic [32:0]          rnd;
        logic signed [SW-1:0] sv;

        if (j == 0) begin : g_first
            assign s_in = A5_Q30;
            assign t_in = i_t;
            assign e_in = i_e;
        end else begin : g_next
            assign s_in = r_r_s[j-1];
            assign t_in = r_r_t[j-1];
            assign e_in = r_r_e[j-1];
        end

        // last step multiplies the polynomial by exp(-x*x)
        if (j == HSTEPS - 1) begin : g_by_e
            assign op = e_in;
        end else begin : g_by_t
            assign op = t_in;
        end

        assign mag = s_in[SW-1] ? 32'(-s_in) : 32'(s_in);
        assign rnd = 33'((r_m_mag[j] + 63'(HALF_Q30)) >> 30);
        assign sv  = r_m_neg[j] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m_mag[j] <= 63'(mag) * 63'(op);
                r_m_neg[j] <= s_in[SW-1];
                r_m_t[j]   <= t_in;
                r_m_e[j]   <= e_in;
                r_r_s[j]   <= sv + horner_add(j);
                r_r_t[j]   <= r_m_t[j];
                r_r_e[j]   <= r_m_e[j];
            end
        end
    end

    // 1 - poly*e, clamped, rounded to Q1.14
    logic signed [SW:0] w_r;
    logic [Q30W-1:0]    w_rc;
    assign w_r = $signed({4'b0, ONE_Q30}) - (SW+1)'(r_r_s[HSTEPS-1]);

    always_comb begin
        if (w_r < 0) begin
            w_rc = '0;
        end else if (w_r > $signed({4'b0, ONE_Q30})) begin
            w_rc = ONE_Q30;
        end else begin
            w_rc = w_r[Q30W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= RESW'((32'(w_rc) + 32'd32768) >> 16);
        end
    end

    assign o_res = r_res;

endmodule
